FILE: hdl/aot_pkg.sv
// Shared types and constants for the affine transform and outcode block.
// Used by every module under hdl; depends on nothing else.
package aot_pkg;

    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int FRAC_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int CODE_W     = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 2 * COORD_W;
    localparam int M_DATA_W   = 80;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_M_XX    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_M_XY    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_M_XT    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_M_YX    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_M_YY    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_M_YT    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_X_LIMIT = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_LIMIT = 3'd7;

    // Register values after reset.
    localparam logic [COORD_W-1:0] RST_UNITY   = 32'h0001_0000;
    localparam logic [COORD_W-1:0] RST_ZERO    = 32'h0000_0000;
    localparam logic [LIMIT_W-1:0] RST_X_LIMIT = 15'd1279;
    localparam logic [LIMIT_W-1:0] RST_Y_LIMIT = 15'd1023;

    // Outcode bit positions.
    localparam int CODE_XLO = 0;
    localparam int CODE_XHI = 1;
    localparam int CODE_YLO = 2;
    localparam int CODE_YHI = 3;

    localparam logic [CODE_W-1:0] OR_ACC_RST  = 4'h0;
    localparam logic [CODE_W-1:0] AND_ACC_RST = 4'hF;

    typedef struct packed {
        logic [COORD_W-1:0] m_xx;
        logic [COORD_W-1:0] m_xy;
        logic [COORD_W-1:0] m_xt;
        logic [COORD_W-1:0] m_yx;
        logic [COORD_W-1:0] m_yy;
        logic [COORD_W-1:0] m_yt;
        logic [LIMIT_W-1:0] x_limit;
        logic [LIMIT_W-1:0] y_limit;
    } cfg_t;

    // Products of one vertex, handed from the multiply stage to the result stage.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [PROD_W-1:0] px_x;
        logic [PROD_W-1:0] px_y;
        logic [PROD_W-1:0] py_x;
        logic [PROD_W-1:0] py_y;
    } prod_t;

endpackage

FILE: hdl/aot_cfg.sv
// Configuration register bank: matrix coefficients, translations and window limits.
// Depends on aot_pkg.
module aot_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [aot_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [aot_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output aot_pkg::cfg_t                  cfg
);
    import aot_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.m_xx    <= RST_UNITY;
            cfg_reg.m_xy    <= RST_ZERO;
            cfg_reg.m_xt    <= RST_ZERO;
            cfg_reg.m_yx    <= RST_ZERO;
            cfg_reg.m_yy    <= RST_UNITY;
            cfg_reg.m_yt    <= RST_ZERO;
            cfg_reg.x_limit <= RST_X_LIMIT;
            cfg_reg.y_limit <= RST_Y_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_M_XX:    cfg_reg.m_xx    <= cfg_wdata;
                REG_M_XY:    cfg_reg.m_xy    <= cfg_wdata;
                REG_M_XT:    cfg_reg.m_xt    <= cfg_wdata;
                REG_M_YX:    cfg_reg.m_yx    <= cfg_wdata;
                REG_M_YY:    cfg_reg.m_yy    <= cfg_wdata;
                REG_M_YT:    cfg_reg.m_yt    <= cfg_wdata;
                REG_X_LIMIT: cfg_reg.x_limit <= cfg_wdata[LIMIT_W-1:0];
                REG_Y_LIMIT: cfg_reg.y_limit <= cfg_wdata[LIMIT_W-1:0];
                default:     cfg_reg.m_xx    <= cfg_reg.m_xx;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/aot_mac.sv
// Multiply stage: the four 32x32 signed products of one vertex, registered.
// Depends on aot_pkg.
module aot_mac (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic                        in_last,
    input  logic [aot_pkg::COORD_W-1:0] in_x,
    input  logic [aot_pkg::COORD_W-1:0] in_y,
    input  aot_pkg::cfg_t               cfg,
    output aot_pkg::prod_t              prod
);
    import aot_pkg::*;

    prod_t prod_reg;
    prod_t prod_next;

    always_comb
    begin
        prod_next.valid = in_valid;
        prod_next.last  = in_last;
        prod_next.px_x  = PROD_W'($signed(in_x) * $signed(cfg.m_xx));
        prod_next.px_y  = PROD_W'($signed(in_y) * $signed(cfg.m_xy));
        prod_next.py_x  = PROD_W'($signed(in_x) * $signed(cfg.m_yx));
        prod_next.py_y  = PROD_W'($signed(in_y) * $signed(cfg.m_yy));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
        end
        else if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/aot_code.sv
// Result stage: sum, scale, translate and saturate, then outcode and list accumulation.
// Depends on aot_pkg; fed by aot_mac.
module aot_code (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  aot_pkg::prod_t              prod,
    input  aot_pkg::cfg_t               cfg,
    output logic                        res_valid,
    output logic                        res_last,
    output logic [aot_pkg::COORD_W-1:0] res_x,
    output logic [aot_pkg::COORD_W-1:0] res_y,
    output logic [aot_pkg::CODE_W-1:0]  res_code,
    output logic [aot_pkg::CODE_W-1:0]  res_union,
    output logic [aot_pkg::CODE_W-1:0]  res_common
);
    import aot_pkg::*;

    localparam int SUM_W = PROD_W + 1;
    localparam int SH_W  = SUM_W - FRAC_W;
    localparam int TOT_W = SH_W + 1;

    logic                valid_reg;
    logic                last_reg;
    logic [COORD_W-1:0]  x_reg, x_next;
    logic [COORD_W-1:0]  y_reg, y_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [CODE_W-1:0]   union_reg, union_next;
    logic [CODE_W-1:0]   common_reg, common_next;
    logic [CODE_W-1:0]   or_acc_reg, or_acc_next;
    logic [CODE_W-1:0]   and_acc_reg, and_acc_next;
    logic                take;

    // Floor of the exact sum of both products over 2^16, plus translation, clamped to 32 bits.
    function automatic logic [COORD_W-1:0] affine_sat(
        input logic [PROD_W-1:0]  p1,
        input logic [PROD_W-1:0]  p2,
        input logic [COORD_W-1:0] t
    );
        logic [SUM_W-1:0] sum;
        logic [TOT_W-1:0] tot;
        logic [COORD_W-1:0] res;
        sum = {p1[PROD_W-1], p1} + {p2[PROD_W-1], p2};
        tot = {sum[SUM_W-1], sum[SUM_W-1:FRAC_W]}
            + {{(TOT_W-COORD_W){t[COORD_W-1]}}, t};
        if (tot[TOT_W-1:COORD_W-1] == {(TOT_W-COORD_W+1){tot[COORD_W-1]}})
        begin
            res = tot[COORD_W-1:0];
        end
        else if (tot[TOT_W-1])
        begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    assign take = en && prod.valid;

    always_comb
    begin
        x_next = affine_sat(prod.px_x, prod.px_y, cfg.m_xt);
        y_next = affine_sat(prod.py_x, prod.py_y, cfg.m_yt);

        code_next           = '0;
        code_next[CODE_XLO] = x_next[COORD_W-1];
        code_next[CODE_XHI] = $signed(x_next) > $signed({1'b0, cfg.x_limit, {FRAC_W{1'b0}}});
        code_next[CODE_YLO] = y_next[COORD_W-1];
        code_next[CODE_YHI] = $signed(y_next) > $signed({1'b0, cfg.y_limit, {FRAC_W{1'b0}}});

        union_next  = or_acc_reg | code_next;
        common_next = and_acc_reg & code_next;

        // The accumulators restart once the last vertex of a list has gone through.
        if (prod.last)
        begin
            or_acc_next  = OR_ACC_RST;
            and_acc_next = AND_ACC_RST;
        end
        else
        begin
            or_acc_next  = union_next;
            and_acc_next = common_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            or_acc_reg  <= OR_ACC_RST;
            and_acc_reg <= AND_ACC_RST;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= prod.valid;
            end
            if (take)
            begin
                or_acc_reg  <= or_acc_next;
                and_acc_reg <= and_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last_reg   <= prod.last;
            x_reg      <= x_next;
            y_reg      <= y_next;
            code_reg   <= code_next;
            union_reg  <= union_next;
            common_reg <= common_next;
        end
    end

    assign res_valid  = valid_reg;
    assign res_last   = last_reg;
    assign res_x      = x_reg;
    assign res_y      = y_reg;
    assign res_code   = code_reg;
    assign res_union  = union_reg;
    assign res_common = common_reg;

    a_acc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && prod.last) |=> (or_acc_reg == OR_ACC_RST && and_acc_reg == AND_ACC_RST))
        else $error("accumulators not restarted after last vertex");

    a_common_in_union: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((common_reg & ~union_reg) == '0))
        else $error("common code has a bit outside the union code");

    a_x_sides: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(code_reg[CODE_XLO] && code_reg[CODE_XHI]))
        else $error("vertex flagged both left and right of the window");

endmodule

FILE: hdl/affine_transform_outcode.sv
// Top level of the affine transform and outcode block: stream ports, input register,
// handshake control. Depends on aot_pkg, aot_cfg, aot_mac and aot_code.
//
// One vertex is taken per clock while the master side does not hold it back; its
// result passes through an input register, a register after the four 32x32
// multipliers, and the result register after the sum, saturation and outcode
// logic before it is presented on the master side. Each stage moves on
// whenever the stage after it is empty or emptying, so the block keeps taking
// vertices while a result waits on the master side and only stops once all
// three stages hold data. The running OR and AND of outcodes are reported
// with every vertex and restart after the one marked by tlast. The matrix
// and window limits should be written only while no vertex is in flight.
module affine_transform_outcode (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [aot_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [aot_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // in_x [31:0], in_y [63:32]
    input  logic [aot_pkg::S_DATA_W-1:0]   s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_x [31:0], out_y [63:32], outcode [67:64], union_code [71:68],
    // common_code [75:72], zero padding [79:76]
    output logic [aot_pkg::M_DATA_W-1:0]   m_axis_tdata,
    output logic                           m_axis_tlast
);
    import aot_pkg::*;

    localparam int PAD_W = M_DATA_W - 2 * COORD_W - 3 * CODE_W;

    cfg_t               cfg;
    prod_t              prod;
    logic               in_valid_reg;
    logic               in_last_reg;
    logic [COORD_W-1:0] in_x_reg;
    logic [COORD_W-1:0] in_y_reg;
    logic               out_en;
    logic               mul_en;
    logic               in_en;
    logic               res_valid;
    logic               res_last;
    logic [COORD_W-1:0] res_x;
    logic [COORD_W-1:0] res_y;
    logic [CODE_W-1:0]  res_code;
    logic [CODE_W-1:0]  res_union;
    logic [CODE_W-1:0]  res_common;

    assign out_en        = !res_valid || m_axis_tready;
    assign mul_en        = !prod.valid || out_en;
    assign in_en         = !in_valid_reg || mul_en;
    assign s_axis_tready = in_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_en)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en && s_axis_tvalid)
        begin
            in_x_reg    <= s_axis_tdata[COORD_W-1:0];
            in_y_reg    <= s_axis_tdata[2*COORD_W-1:COORD_W];
            in_last_reg <= s_axis_tlast;
        end
    end

    aot_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    aot_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (mul_en),
        .in_valid (in_valid_reg),
        .in_last  (in_last_reg),
        .in_x     (in_x_reg),
        .in_y     (in_y_reg),
        .cfg      (cfg),
        .prod     (prod)
    );

    aot_code u_code (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (out_en),
        .prod       (prod),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res_last   (res_last),
        .res_x      (res_x),
        .res_y      (res_y),
        .res_code   (res_code),
        .res_union  (res_union),
        .res_common (res_common)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tlast  = res_last;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, res_common, res_union, res_code, res_y, res_x};

endmodule

FILE: tb/affine_transform_outcode_tb.sv
// Self-checking testbench for the affine transform and outcode block.
// Predicts each transformed vertex, outcode and list flags in the testbench itself.
// Depends on aot_pkg and affine_transform_outcode under hdl.
module affine_transform_outcode_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import aot_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CODE_W-1:0]  code;
        logic [CODE_W-1:0]  any_code;
        logic [CODE_W-1:0]  all_code;
        logic               last;
    } vertex_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;

    // Register shadow, indexed by register index, and the running list flags.
    logic [CFG_DATA_W-1:0] reg_shadow [8];
    logic [CFG_DATA_W-1:0] reg_next [8];
    logic [CODE_W-1:0]     run_or;
    logic [CODE_W-1:0]     run_and;

    vertex_result_t pending_results [$];
    vertex_result_t want;

    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned error_count    = 0;
    int unsigned vertices_sent  = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used  = 0;
    int unsigned lists_closed   = 0;
    int unsigned list_left      = 0;

    affine_transform_outcode DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("TIMEOUT with %0d results outstanding", pending_results.size());
        $display("affine_transform_outcode: mismatch");
        $finish;
    end

    // floor((a*b + c*d) / 2^16) + t, saturated to 32 bits. 66 bits hold the
    // sum of two full-range products without overflow.
    function automatic logic [COORD_W-1:0] transform_coord(
        logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
        logic [COORD_W-1:0] c, logic [COORD_W-1:0] d,
        logic [COORD_W-1:0] t);
        logic signed [65:0] ea, eb, ec, ed, et, acc;
        ea = $signed(a);
        eb = $signed(b);
        ec = $signed(c);
        ed = $signed(d);
        et = $signed(t);
        acc = ea * eb + ec * ed;
        acc = (acc >>> FRAC_W) + et;
        if (acc > 66'sd2147483647)
            return 32'h7FFF_FFFF;
        if (acc < -66'sd2147483648)
            return 32'h8000_0000;
        return acc[COORD_W-1:0];
    endfunction

    function automatic vertex_result_t predict_vertex(
        logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
        vertex_result_t r;
        logic [COORD_W-1:0] x_edge, y_edge;
        x_edge = {1'b0, reg_shadow[REG_X_LIMIT][LIMIT_W-1:0], 16'h0000};
        y_edge = {1'b0, reg_shadow[REG_Y_LIMIT][LIMIT_W-1:0], 16'h0000};
        r.x = transform_coord(x, reg_shadow[REG_M_XX], y, reg_shadow[REG_M_XY],
                              reg_shadow[REG_M_XT]);
        r.y = transform_coord(x, reg_shadow[REG_M_YX], y, reg_shadow[REG_M_YY],
                              reg_shadow[REG_M_YT]);
        r.code = '0;
        r.code[CODE_XLO] = r.x[COORD_W-1];
        r.code[CODE_XHI] = $signed(r.x) > $signed(x_edge);
        r.code[CODE_YLO] = r.y[COORD_W-1];
        r.code[CODE_YHI] = $signed(r.y) > $signed(y_edge);
        r.any_code = run_or | r.code;
        r.all_code = run_and & r.code;
        r.last = last;
        if (last)
        begin
            run_or  = OR_ACC_RST;
            run_and = AND_ACC_RST;
        end
        else
        begin
            run_or  = r.any_code;
            run_and = r.all_code;
        end
        return r;
    endfunction

    function automatic void shadow_reset();
        reg_shadow[REG_M_XX]    = RST_UNITY;
        reg_shadow[REG_M_XY]    = RST_ZERO;
        reg_shadow[REG_M_XT]    = RST_ZERO;
        reg_shadow[REG_M_YX]    = RST_ZERO;
        reg_shadow[REG_M_YY]    = RST_UNITY;
        reg_shadow[REG_M_YT]    = RST_ZERO;
        reg_shadow[REG_X_LIMIT] = 32'(RST_X_LIMIT);
        reg_shadow[REG_Y_LIMIT] = 32'(RST_Y_LIMIT);
        run_or  = OR_ACC_RST;
        run_and = AND_ACC_RST;
    endfunction

    task automatic report_error(string what, logic [31:0] got, logic [31:0] exp);
        error_count++;
        $display("ERROR at %0t ns, result %0d: %s is %h, expected %h",
                 $time, results_checked, what, got, exp);
    endtask

    // Result checker; the receiver's stalls are drawn here as well.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_error("unexpected transaction, out_x", m_axis_tdata[31:0], '0);
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_axis_tdata[31:0] !== want.x)
                    report_error("out_x", m_axis_tdata[31:0], want.x);
                if (m_axis_tdata[63:32] !== want.y)
                    report_error("out_y", m_axis_tdata[63:32], want.y);
                if (m_axis_tdata[67:64] !== want.code)
                    report_error("outcode", 32'(m_axis_tdata[67:64]), 32'(want.code));
                if (m_axis_tdata[71:68] !== want.any_code)
                    report_error("union_code", 32'(m_axis_tdata[71:68]), 32'(want.any_code));
                if (m_axis_tdata[75:72] !== want.all_code)
                    report_error("common_code", 32'(m_axis_tdata[75:72]), 32'(want.all_code));
                if (m_axis_tlast !== want.last)
                    report_error("tlast", 32'(m_axis_tlast), 32'(want.last));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        pending_results.push_back(predict_vertex(x, y, last));
        vertices_sent++;
        if (last)
            lists_closed++;
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all eight registers from reg_next, only with the pipeline empty.
    task automatic apply_config();
        drain_pipeline();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(i);
            cfg_wdata <= reg_next[i];
            @(posedge clk);
            if (CFG_ADDR_W'(i) == REG_X_LIMIT || CFG_ADDR_W'(i) == REG_Y_LIMIT)
                reg_shadow[i] = {17'h0, reg_next[i][LIMIT_W-1:0]};
            else
                reg_shadow[i] = reg_next[i];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic logic [31:0] signed_upto(int unsigned mag);
        return 32'($urandom_range(2 * mag) - mag);
    endfunction

    function automatic logic [31:0] limit_word(int unsigned lim);
        // Bits above the limit field are junk that the block must drop.
        return ($urandom() & 32'hFFFF_8000) | 32'(lim);
    endfunction

    task automatic test_reset_window();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_vertex(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_vertex({16'd1279, 16'h0}, {16'd1023, 16'h0}, 1'b0);
        send_vertex({16'd1279, 16'h1}, 32'h0001_0000, 1'b0);
        send_vertex(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_vertex(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'h0010_0000, {16'd1023, 16'h1}, 1'b1);
        send_vertex(32'hFFFB_0000, {16'd2000, 16'h0}, 1'b1);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    endtask

    task automatic test_extreme_matrix();
        reg_next[REG_M_XX]    = 32'h8000_0000;
        reg_next[REG_M_XY]    = 32'h8000_0000;
        reg_next[REG_M_XT]    = 32'h7FFF_FFFF;
        reg_next[REG_M_YX]    = 32'h7FFF_FFFF;
        reg_next[REG_M_YY]    = 32'h8000_0000;
        reg_next[REG_M_YT]    = 32'h8000_0000;
        reg_next[REG_X_LIMIT] = 32'hFFFF_8000;
        reg_next[REG_Y_LIMIT] = 32'hFFFF_FFFF;
        apply_config();
        send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_vertex(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
    endtask

    // Half-unit scale checks flooring of products toward minus infinity.
    task automatic test_rounding();
        reg_next[REG_M_XX]    = 32'h0000_8000;
        reg_next[REG_M_XY]    = 32'h0000_8000;
        reg_next[REG_M_XT]    = 32'h0000_0000;
        reg_next[REG_M_YX]    = 32'h0000_0000;
        reg_next[REG_M_YY]    = 32'h0000_0000;
        reg_next[REG_M_YT]    = 32'hFFFF_FFFF;
        reg_next[REG_X_LIMIT] = 32'h0000_0000;
        reg_next[REG_Y_LIMIT] = 32'h0000_7FFF;
        apply_config();
        send_vertex(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_vertex(32'h0000_0001, 32'h0000_0000, 1'b0);
        send_vertex(32'h0000_0001, 32'h0000_0001, 1'b0);
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'h0000_0000, 32'h0000_0000, 1'b1);
    endtask

    task automatic pick_config(bit tame);
        if (tame)
        begin
            if ($urandom_range(2) == 0)
            begin
                reg_next[REG_M_XX] = RST_UNITY;
                reg_next[REG_M_XY] = RST_ZERO;
                reg_next[REG_M_YX] = RST_ZERO;
                reg_next[REG_M_YY] = RST_UNITY;
            end
            else
            begin
                reg_next[REG_M_XX] = 32'h0001_0000 + signed_upto(8192);
                reg_next[REG_M_XY] = signed_upto(4096);
                reg_next[REG_M_YX] = signed_upto(4096);
                reg_next[REG_M_YY] = 32'h0001_0000 + signed_upto(8192);
            end
            reg_next[REG_M_XT]    = signed_upto(64 * 65536);
            reg_next[REG_M_YT]    = signed_upto(64 * 65536);
            reg_next[REG_X_LIMIT] = limit_word($urandom_range(8000));
            reg_next[REG_Y_LIMIT] = limit_word($urandom_range(8000));
        end
        else
        begin
            for (int i = 0; i < 6; i++)
                case ($urandom_range(3))
                    0: reg_next[i] = $urandom();
                    1: reg_next[i] = signed_upto(4 * 65536);
                    2: reg_next[i] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: reg_next[i] = signed_upto(1 << 24);
                endcase
            reg_next[REG_X_LIMIT] = limit_word($urandom_range(1) ? 32767 : $urandom_range(32767));
            reg_next[REG_Y_LIMIT] = limit_word($urandom_range(1) ? 0 : $urandom_range(32767));
        end
        apply_config();
    endtask

    // Coordinate around the window so every outcode bit is exercised; a few
    // land on the window edge itself after the translation is taken off.
    function automatic logic [31:0] near_window(int unsigned lim, logic [31:0] shift);
        int span;
        int pix;
        span = lim + 8;
        case ($urandom_range(7))
            0: return $urandom();
            1: return {1'b0, lim[14:0], 16'h0} - shift + 32'($urandom_range(2)) - 32'd1;
            2: return 32'h0000_0000 - shift + 32'($urandom_range(2)) - 32'd1;
            default:
            begin
                pix = $urandom_range(3 * span) - span;
                return {pix[15:0], 16'($urandom())};
            end
        endcase
    endfunction

    task automatic run_random_phase(int unsigned count, bit tame);
        logic [31:0] x, y;
        logic        last;
        pick_config(tame);
        repeat (count)
        begin
            if (list_left == 0)
                list_left = ($urandom_range(9) == 0) ? $urandom_range(40, 8)
                                                     : $urandom_range(6, 1);
            list_left--;
            last = (list_left == 0);
            if (tame)
            begin
                x = near_window(reg_shadow[REG_X_LIMIT], reg_shadow[REG_M_XT]);
                y = near_window(reg_shadow[REG_Y_LIMIT], reg_shadow[REG_M_YT]);
            end
            else if ($urandom_range(1))
            begin
                x = $urandom();
                y = $urandom();
            end
            else
            begin
                x = signed_upto(4 * 65536);
                y = signed_upto(4 * 65536);
            end
            send_vertex(x, y, last);
        end
    endtask

    task automatic test_random_lists();
        for (int mode = 0; mode < 3; mode++)
        begin
            src_idle_pct  = (mode == 0) ? 37 : (mode == 1) ? 84 : 0;
            sink_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 37 : 0;
            run_random_phase(255, 1'b1);
            run_random_phase(255, 1'b0);
        end
    endtask

    initial
    begin
        shadow_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window();
        test_extreme_matrix();
        test_rounding();
        test_random_lists();
        drain_pipeline();
        repeat (10) @(posedge clk);
        $display("Run covered %0d vertices in %0d closed lists over %0d register settings,",
                 vertices_sent, lists_closed, settings_used + 1);
        $display("with saturation, flooring and window edges under three pacing modes.");
        if (error_count == 0 && results_checked == vertices_sent)
            $display("affine_transform_outcode: match");
        else
            $display("affine_transform_outcode: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
hdl/aot_pkg.sv
hdl/aot_cfg.sv
hdl/aot_mac.sv
hdl/aot_code.sv
hdl/affine_transform_outcode.sv
tb/affine_transform_outcode_tb.sv
